FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register indexes and limits of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIXEL_IN_W = 8;
    localparam int MAG_W      = 11;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MAG_W-1:0] MAG_MAX    = 11'd2047;
    localparam logic [FH_W-1:0]  MAX_HEIGHT = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

endpackage

FILE: rtl/sem_pix_if.sv
// ----------------------------------------------------------------------------
// sem_pix_if
// Pixel stream channel: valid/ready handshake carrying one grey pixel.
// ----------------------------------------------------------------------------
interface sem_pix_if;
    import sem_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIXEL_IN_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

FILE: rtl/sem_res_if.sv
// ----------------------------------------------------------------------------
// sem_res_if
// Result channel: valid/ready handshake carrying one edge magnitude item.
// ----------------------------------------------------------------------------
interface sem_res_if;
    import sem_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MAG_W-1:0]     magnitude;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 frame_last;

    modport source (output valid, output magnitude, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input magnitude, input out_row, input out_col,
                    input frame_last, output ready);

endinterface

FILE: rtl/sem_scan.sv
// ----------------------------------------------------------------------------
// sem_scan
// Frame size registers and raster row/column counters with border flags.
// ----------------------------------------------------------------------------
module sem_scan #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_step,
    output logic [sem_pkg::ROW_W-1:0]       o_row,
    output logic [CW-1:0]                   o_col,
    output logic                            o_emit,
    output logic                            o_full,
    output logic                            o_last
);
    import sem_pkg::*;

    localparam int EW = FH_W;

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] hm1;
    logic [CW-1:0]    wm1;
    logic [EW-1:0]    fw_ext;

    assign fw_ext = EW'(r_frame_width);

    always_comb begin
        if (r_frame_height < FH_W'(3)) begin
            hm1 = ROW_W'(2);
        end else if (r_frame_height > MAX_HEIGHT) begin
            hm1 = ROW_W'(MAX_HEIGHT - FH_W'(1));
        end else begin
            hm1 = ROW_W'(r_frame_height - FH_W'(1));
        end
        if (fw_ext < EW'(3)) begin
            wm1 = CW'(2);
        end else if (fw_ext >= EW'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(fw_ext - EW'(1));
        end
    end

    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_emit = (r_row != '0) && (r_col != '0);
    assign o_full = (r_row > ROW_W'(1)) && (r_col > CW'(1));
    assign o_last = (r_row == hm1) && (r_col == wm1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(1024);
            r_frame_height <= FH_W'(1024);
            r_row          <= '0;
            r_col          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FW_W-1:0];
                    r_row         <= '0;
                    r_col         <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FH_W-1:0];
                    r_row          <= '0;
                    r_col          <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_step) begin
            if (r_col >= wm1) begin
                r_col <= '0;
                r_row <= (r_row >= hm1) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

endmodule

FILE: rtl/sem_line_buf.sv
// ----------------------------------------------------------------------------
// sem_line_buf
// Two line stores of the previous rows, registered read, one write per item.
// ----------------------------------------------------------------------------
module sem_line_buf #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [CW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [CW-1:0]         i_wr_addr,
    input  logic [PIXEL_BITS-1:0] i_wr_pixel,
    output logic [PIXEL_BITS-1:0] o_up,
    output logic [PIXEL_BITS-1:0] o_mid
);
    logic [PIXEL_BITS-1:0] r_upper_mem  [0:MAX_WIDTH-1];
    logic [PIXEL_BITS-1:0] r_middle_mem [0:MAX_WIDTH-1];
    logic [PIXEL_BITS-1:0] r_up;
    logic [PIXEL_BITS-1:0] r_mid;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up <= r_upper_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr] <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid <= r_middle_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_middle_mem[i_wr_addr] <= i_wr_pixel;
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

FILE: rtl/sem_grad.sv
// ----------------------------------------------------------------------------
// sem_grad
// Sobel x and y gradients over a 3x3 window, |Gx|+|Gy| saturated to 11 bits.
// ----------------------------------------------------------------------------
module sem_grad #(
    parameter int PIXEL_BITS = 8
) (
    input  logic [PIXEL_BITS-1:0]       i_win [0:5],
    input  logic [PIXEL_BITS-1:0]       i_up,
    input  logic [PIXEL_BITS-1:0]       i_mid,
    input  logic [PIXEL_BITS-1:0]       i_cur,
    output logic [sem_pkg::MAG_W-1:0]   o_mag
);
    import sem_pkg::*;

    localparam int SW = PIXEL_BITS + 2;
    localparam int DW = PIXEL_BITS + 3;
    localparam int MW = PIXEL_BITS + 3;
    localparam int XW = (MW > MAG_W) ? MW : MAG_W;

    logic [SW-1:0]        sx_right;
    logic [SW-1:0]        sx_left;
    logic [SW-1:0]        sy_top;
    logic [SW-1:0]        sy_bot;
    logic signed [DW-1:0] gx;
    logic signed [DW-1:0] gy;
    logic [SW-1:0]        ax;
    logic [SW-1:0]        ay;
    logic [MW-1:0]        sum;
    logic [XW-1:0]        sum_ext;

    always_comb begin
        sx_right = SW'(i_up) + {1'b0, i_mid, 1'b0} + SW'(i_cur);
        sx_left  = SW'(i_win[0]) + {1'b0, i_win[2], 1'b0} + SW'(i_win[4]);
        sy_top   = SW'(i_win[0]) + {1'b0, i_win[1], 1'b0} + SW'(i_up);
        sy_bot   = SW'(i_win[4]) + {1'b0, i_win[5], 1'b0} + SW'(i_cur);
        gx       = $signed({1'b0, sx_right}) - $signed({1'b0, sx_left});
        gy       = $signed({1'b0, sy_top}) - $signed({1'b0, sy_bot});
        ax       = gx[DW-1] ? SW'(-gx) : SW'(gx);
        ay       = gy[DW-1] ? SW'(-gy) : SW'(gy);
        sum      = MW'(ax) + MW'(ay);
        sum_ext  = XW'(sum);
        o_mag    = (sum_ext > XW'(MAG_MAX)) ? MAG_MAX : MAG_W'(sum_ext);
    end

endmodule

FILE: rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel |Gx|+|Gy| over raster-order grey pixels.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock and, once the stream is running, delivers
// one result item per clock while the sink keeps ready high. Pixel (r,c) is
// held in the r_a_ registers; the result for the centre (r-1,c-1) is loaded
// into the output register when that stage advances. The rate is set by the
// single read and single write port of each line store, both used once per
// item. Pixels in row 0 or column 0 give no result; the last row and column
// are never sent and are zero by rule. A frame_width or frame_height write
// restarts the frame at (0,0). No clearing pass after reset: line store
// contents only reach results that are zero by rule.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sem_pix_if.sink                         i_pix,
    sem_res_if.source                       o_res
);
    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [ROW_W-1:0]      s_row;
    logic [CW-1:0]         s_col;
    logic                  s_emit;
    logic                  s_full;
    logic                  s_last;
    logic                  accept;
    logic                  adv;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] mid;
    logic [MAG_W-1:0]      grad_mag;

    logic                  r_a_valid;
    logic [PIXEL_BITS-1:0] r_a_pix;
    logic [ROW_W-1:0]      r_a_row;
    logic [CW-1:0]         r_a_col;
    logic                  r_a_emit;
    logic                  r_a_full;
    logic                  r_a_last;
    logic [PIXEL_BITS-1:0] r_win [0:5];
    logic [PIXEL_BITS-1:0] n_win [0:5];

    logic                  r_out_valid;
    logic [MAG_W-1:0]      r_mag;
    logic [ROW_W-1:0]      r_row;
    logic [CW-1:0]         r_col;
    logic                  r_last;
    logic [CW-1:0]         col_m1;

    assign adv         = r_a_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_a_valid || adv;
    assign accept      = i_pix.valid && i_pix.ready;

    sem_scan #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .o_row      (s_row),
        .o_col      (s_col),
        .o_emit     (s_emit),
        .o_full     (s_full),
        .o_last     (s_last)
    );

    sem_line_buf #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS), .CW(CW)) u_line_buf (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (s_col),
        .i_wr_en    (adv),
        .i_wr_addr  (r_a_col),
        .i_wr_pixel (r_a_pix),
        .o_up       (up),
        .o_mid      (mid)
    );

    sem_grad #(.PIXEL_BITS(PIXEL_BITS)) u_grad (
        .i_win (r_win),
        .i_up  (up),
        .i_mid (mid),
        .i_cur (r_a_pix),
        .o_mag (grad_mag)
    );

    // window shift: columns c-2 <- c-1 <- new column
    always_comb begin
        n_win[0] = r_win[1];
        n_win[2] = r_win[3];
        n_win[4] = r_win[5];
        n_win[1] = up;
        n_win[3] = mid;
        n_win[5] = r_a_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
        if (accept) begin
            r_a_pix  <= PIXEL_BITS'(i_pix.pixel);
            r_a_row  <= s_row;
            r_a_col  <= s_col;
            r_a_emit <= s_emit;
            r_a_full <= s_full;
            r_a_last <= s_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (adv) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_a_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_a_emit) begin
            r_mag  <= r_a_full ? grad_mag : '0;
            r_row  <= r_a_row - ROW_W'(1);
            r_col  <= r_a_col;
            r_last <= r_a_last;
        end
    end

    assign col_m1           = r_col - CW'(1);
    assign o_res.valid      = r_out_valid;
    assign o_res.magnitude  = r_mag;
    assign o_res.out_row    = r_row;
    assign o_res.out_col    = OUT_COL_W'(col_m1);
    assign o_res.frame_last = r_last;

`ifndef SYNTHESIS
    a_lb_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && adv) |-> (s_col != r_a_col))
        else $error("line store read and write hit the same column");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.out_row == '0 || o_res.out_col == '0))
            |-> (o_res.magnitude == '0))
        else $error("border result with non-zero magnitude");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_a_emit) |=> !o_res.valid)
        else $error("result raised by an item that gives none");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_a_emit && r_a_last) |=> (o_res.valid && o_res.frame_last))
        else $error("frame end result lost");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sobel_edge_magnitude. Raster frames of many sizes
// stream through the pixel channel while an in-bench Sobel window model
// predicts each result item. The result channel is compared item by item,
// under source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import sem_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int MAX_ROWS     = 4096;
    localparam int SETTLE_CYC   = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 2'd3;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum logic [1:0] {PX_UNIFORM, PX_BINARY, PX_NOISY, PX_SPARSE} t_px_style;

    typedef struct packed {
        logic [MAG_W-1:0]     magnitude;
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 frame_last;
    } t_edge_res;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sem_pix_if pix_ch ();
    sem_res_if res_ch ();

    sobel_edge_magnitude #(
        .MAX_WIDTH  (LINE_DEPTH),
        .PIXEL_BITS (PIXEL_IN_W)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    // window model state
    bit [PIXEL_IN_W-1:0] line_top [LINE_DEPTH];
    bit [PIXEL_IN_W-1:0] line_mid [LINE_DEPTH];
    int                  win_old [3];
    int                  win_new [3];
    int unsigned         cur_row = 0;
    int unsigned         cur_col = 0;
    logic [FW_W-1:0]     width_reg  = 11'd1024;
    logic [FH_W-1:0]     height_reg = 13'd1024;

    t_edge_res             edge_q [$];
    logic [PIXEL_IN_W-1:0] pix_q [$];
    t_idle                 idle_mode = IDLE_NONE;
    int                    n_fail    = 0;
    int                    stuck_cyc = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_reg < 3) return 3;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg < 3) return 3;
        if (height_reg > MAX_ROWS) return MAX_ROWS;
        return height_reg;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_FRAME_WIDTH) begin
            width_reg = val[FW_W-1:0];
        end else if (idx == CFG_FRAME_HEIGHT) begin
            height_reg = val;
        end else begin
            return;
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void predict_edge(logic [PIXEL_IN_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int          up;
        int          md;
        int          lo;
        int          gx;
        int          gy;
        int          mag;
        t_edge_res   item;
        w  = active_width();
        h  = active_height();
        up = line_top[cur_col];
        md = line_mid[cur_col];
        lo = px;
        line_top[cur_col] = line_mid[cur_col];
        line_mid[cur_col] = px;
        if (cur_row >= 1 && cur_col >= 1) begin
            mag = 0;
            if (cur_row >= 2 && cur_col >= 2) begin
                gx  = (up + 2 * md + lo) - (win_old[0] + 2 * win_old[1] + win_old[2]);
                gy  = (win_old[0] + 2 * win_new[0] + up) - (win_old[2] + 2 * win_new[2] + lo);
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
            end
            item.magnitude  = mag[MAG_W-1:0];
            item.out_row    = ROW_W'(cur_row - 1);
            item.out_col    = OUT_COL_W'(cur_col - 1);
            item.frame_last = (cur_row == h - 1) && (cur_col == w - 1);
            edge_q.push_back(item);
        end
        win_old = win_new;
        win_new = '{up, md, lo};
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            if (n_fail < REPORT_LIMIT)
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void check_result();
        t_edge_res want;
        if (edge_q.size() == 0) begin
            if (n_fail < REPORT_LIMIT)
                $error("result item with none expected: row %0d col %0d",
                       res_ch.out_row, res_ch.out_col);
            n_fail++;
            return;
        end
        want = edge_q.pop_front();
        check_field("magnitude",  want.magnitude,  res_ch.magnitude);
        check_field("out_row",    want.out_row,    res_ch.out_row);
        check_field("out_col",    want.out_col,    res_ch.out_col);
        check_field("frame_last", want.frame_last, res_ch.frame_last);
    endfunction

    function automatic bit sender_idle();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 61;
            IDLE_BOTH: return $urandom_range(0, 99) < 33;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 61;
            IDLE_BOTH: return $urandom_range(0, 99) < 33;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic [PIXEL_IN_W-1:0] pick_pixel(t_px_style style,
                                                         logic [PIXEL_IN_W-1:0] level);
        int v;
        case (style)
            PX_BINARY: return $urandom_range(0, 1) ? '1 : '0;
            PX_NOISY: begin
                v = int'(level) + int'($urandom_range(0, 32)) - 16;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return v[PIXEL_IN_W-1:0];
            end
            PX_SPARSE: return ($urandom_range(0, 9) == 0) ?
                              PIXEL_IN_W'($urandom_range(0, 255)) : level;
            default:   return PIXEL_IN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_pixels(int count, t_px_style style);
        logic [PIXEL_IN_W-1:0] level;
        level = PIXEL_IN_W'($urandom_range(0, 255));
        repeat (count) pix_q.push_back(pick_pixel(style, level));
    endfunction

    function automatic void queue_row(logic [PIXEL_IN_W-1:0] a, logic [PIXEL_IN_W-1:0] b,
                                      logic [PIXEL_IN_W-1:0] c);
        pix_q.push_back(a);
        pix_q.push_back(b);
        pix_q.push_back(c);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg_write(idx, val);
    endtask

    task automatic wait_drained();
        while (pix_q.size() != 0 || pix_ch.valid || edge_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // pixel driver
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_ch.ready) begin
            if (pix_q.size() != 0 && !sender_idle()) begin
                pix_ch.valid <= 1'b1;
                pix_ch.pixel <= pix_q.pop_front();
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !receiver_stall();
            if (pix_ch.valid && pix_ch.ready) predict_edge(pix_ch.pixel);
            if (res_ch.valid && res_ch.ready) check_result();
        end
    end

    // watchdog on lack of progress
    always @(posedge clk) begin
        if (rst_n) begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
                stuck_cyc <= 0;
            else
                stuck_cyc <= stuck_cyc + 1;
            if (stuck_cyc >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned w_set;
        int unsigned h_set;
        int          n_px;
        int          split;
        t_px_style   style;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        res_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: nothing comes out in row 0
        queue_pixels(12, PX_UNIFORM);
        wait_drained();

        // smallest frame, steepest edge, all-ones and alternating bits
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        queue_row(8'd0, 8'd255, 8'd255);
        queue_row(8'd0, 8'd128, 8'd255);
        queue_row(8'd0, 8'd0, 8'd0);
        queue_row(8'hAA, 8'h55, 8'hFF);
        queue_row(8'h55, 8'hAA, 8'h00);
        wait_drained();
        // unused indexes must leave the frame position alone
        write_reg(CFG_IDX_SPARE, 13'h1FFF);
        write_reg(CFG_IDX_TOP, 13'h0000);
        queue_row(8'hFF, 8'h01, 8'h80);
        queue_row(8'h7F, 8'hFE, 8'h01);

        for (int ph = 0; ph < 16; ph++) begin
            idle_mode = t_idle'(ph % 4);
            wait_drained();
            w_set = $urandom_range(3, 12);
            h_set = $urandom_range(3, 6);
            if (ph % 8 == 3) w_set = $urandom_range(0, 2);
            if (ph % 8 == 5) h_set = $urandom_range(0, 2);
            if (ph % 5 != 4)
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_set | ($urandom_range(0, 3) << 11)));
            write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_set));
            n_px  = $urandom_range(10, 30);
            style = t_px_style'($urandom_range(0, 3));
            if (ph == 0 || $urandom_range(0, 2) == 0) begin
                split = $urandom_range(1, n_px - 1);
                queue_pixels(split, style);
                wait_drained();
                if ($urandom_range(0, 1))
                    write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE : CFG_IDX_TOP,
                              CFG_DATA_W'($urandom));
                queue_pixels(n_px - split, style);
            end else begin
                queue_pixels(n_px, style);
            end
        end

        // widest frame, first row only
        idle_mode = IDLE_BOTH;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 13'd1024);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        queue_pixels(16, PX_UNIFORM);

        // width data folds to 11 bits then clamps; height clamps up
        idle_mode = IDLE_SEND;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 13'h0FFF);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        queue_pixels(12, PX_BINARY);

        // tallest frame, height clamped from the top of the field
        idle_mode = IDLE_RECV;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 13'h1803);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        queue_pixels(20, PX_UNIFORM);

        idle_mode = IDLE_NONE;
        wait_drained();
        write_reg(CFG_FRAME_HEIGHT, 13'd4096);
        queue_pixels(30, PX_NOISY);

        while (pix_q.size() != 0 || pix_ch.valid) @(posedge clk);
        for (int k = 0; k < STALL_LIMIT / 2 && edge_q.size() != 0; k++) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (edge_q.size() != 0) begin
            $error("%0d expected result items never arrived", edge_q.size());
            n_fail++;
        end

        if (n_fail == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/sem_pkg.sv
rtl/sem_pix_if.sv
rtl/sem_res_if.sv
rtl/sem_scan.sv
rtl/sem_line_buf.sv
rtl/sem_grad.sv
rtl/sobel_edge_magnitude.sv
tb/tb_top.sv
